// ===== rtl/core/hvn_pkg.sv =====
// Shared constants and types for the hashed 1-D value noise core.
// Used by every module of the core; depends on nothing.
package hvn_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam int unsigned LAT_STAGES   = 2;
  localparam int unsigned HASH_STAGES  = 6;
  localparam int unsigned BLEND_STAGES = 2;
  localparam int unsigned NUM_STAGES   = LAT_STAGES + HASH_STAGES + BLEND_STAGES;

  localparam int unsigned SCALE_W = 24;
  localparam int unsigned SEED_W  = 32;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned NOISE_W = 16;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_SEED = 2'd1;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;
  localparam logic [SEED_W-1:0]  SEED_RESET  = 32'd867855155;

  // 0.1031 as Q0.32, and 33.33 split into integer and Q0.32 fraction
  localparam logic [28:0] HASH_MUL    = 29'd442811128;
  localparam logic [31:0] HASH_ADD_LO = 32'd1417339208;
  localparam logic [5:0]  HASH_ADD_HI = 6'd33;

  localparam logic [NOISE_W-1:0] SIGN_FLIP = 16'h8000;

  typedef struct packed {
    logic [LAT_STAGES-1:0]   lat;
    logic [HASH_STAGES-1:0]  hash;
    logic [BLEND_STAGES-1:0] blend;
  } stage_en_t;

endpackage

// ===== rtl/core/hvn_lattice.sv =====
// Lattice split: scales the position and forms both hash arguments.
// Two register stages; uses hvn_pkg.
module hvn_lattice #(
  parameter int unsigned FRAC_BITS = hvn_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic [hvn_pkg::LAT_STAGES-1:0] en_i,
  input  logic [hvn_pkg::POS_W-1:0]     position_i,
  input  logic [hvn_pkg::SCALE_W-1:0]   scale_i,
  input  logic [hvn_pkg::SEED_W-1:0]    seed_i,
  output logic [31:0]                   q0_o,
  output logic [31:0]                   q1_o,
  output logic [FRAC_BITS-1:0]          t_o
);
  import hvn_pkg::*;

  localparam int unsigned PROD_W = POS_W + SCALE_W;

  logic [PROD_W-1:0]    prod;
  logic [15:0]          idx_q;
  logic [FRAC_BITS-1:0] t_q;
  logic [15:0]          idx_inc;
  logic [31:0]          q0_d, q1_d;
  logic [31:0]          q0_q, q1_q;
  logic [FRAC_BITS-1:0] t2_q;

  assign prod = PROD_W'(position_i) * PROD_W'(scale_i);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      idx_q <= prod[47:32];
      t_q   <= prod[31 -: FRAC_BITS];
    end
  end

  assign idx_inc = idx_q + 16'd1;
  assign q0_d    = {idx_q, 16'd0} + seed_i;
  assign q1_d    = {idx_inc, 16'd0} + seed_i;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      q0_q <= q0_d;
      q1_q <= q1_d;
      t2_q <= t_q;
    end
  end

  assign q0_o = q0_q;
  assign q1_o = q1_q;
  assign t_o  = t2_q;

endmodule

// ===== rtl/core/hvn_hash.sv =====
// Sine-free fract hash of a Q16.16 argument into a Q0.32 value.
// Six register stages, one multiply or wide add each; uses hvn_pkg.
module hvn_hash (
  input  logic                            clk_i,
  input  logic [hvn_pkg::HASH_STAGES-1:0] en_i,
  input  logic [31:0]                     q_i,
  output logic [31:0]                     h_o
);
  import hvn_pkg::*;

  logic [60:0] xm;
  logic [31:0] x_q;
  logic [32:0] s_lo;
  logic [31:0] x2_q, slo_q;
  logic [5:0]  shi_q;
  logic [63:0] pl;
  logic [37:0] ph;
  logic [31:0] pl_q;
  logic [37:0] ph_q;
  logic [37:0] y;
  logic [5:0]  yh_q;
  logic [31:0] yl_q;
  logic [37:0] a;
  logic [63:0] b;
  logic [29:0] a_q;
  logic [31:0] b_q;
  logic [31:0] h_q;

  // x = fract(q * 0.1031)
  assign xm = 61'(q_i) * 61'(HASH_MUL);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      x_q <= xm[47:16];
    end
  end

  // s = x + 33.33
  assign s_lo = {1'b0, x_q} + {1'b0, HASH_ADD_LO};

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      x2_q  <= x_q;
      slo_q <= s_lo[31:0];
      shi_q <= HASH_ADD_HI + 6'(s_lo[32]);
    end
  end

  // y = x * s, 32 fraction bits kept
  assign pl = 64'(x2_q) * 64'(slo_q);
  assign ph = 38'(x2_q) * 38'(shi_q);

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      pl_q <= pl[63:32];
      ph_q <= ph;
    end
  end

  assign y = ph_q + 38'(pl_q);

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      yh_q <= y[37:32];
      yl_q <= y[31:0];
    end
  end

  // fract(2*y*y) = 4*yh*yl + yl*yl/2^31, modulo 1
  assign a = 38'(yh_q) * 38'(yl_q);
  assign b = 64'(yl_q) * 64'(yl_q);

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      a_q <= a[29:0];
      b_q <= b[62:31];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      h_q <= {a_q, 2'b00} + b_q;
    end
  end

  assign h_o = h_q;

endmodule

// ===== rtl/core/hvn_blend.sv =====
// Linear blend of the two lattice hashes and conversion to signed Q1.15.
// Carries the fraction alongside the hash stages; uses hvn_pkg.
module hvn_blend #(
  parameter int unsigned FRAC_BITS = hvn_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  hvn_pkg::stage_en_t        en_i,
  input  logic [FRAC_BITS-1:0]      t_i,
  input  logic [31:0]               h0_i,
  input  logic [31:0]               h1_i,
  output logic [hvn_pkg::NOISE_W-1:0] noise_o
);
  import hvn_pkg::*;

  localparam int unsigned PW = FRAC_BITS + 33;
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [FRAC_BITS-1:0] t_q [HASH_STAGES];
  logic [FRAC_BITS:0]   w0;
  logic [PW-1:0]        m0_q, m1_q;
  logic [PW-1:0]        sum;
  logic [NOISE_W-1:0]   noise_q;

  // hold the fraction in step with the hash pipeline
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < HASH_STAGES; k++) begin
      if (en_i.hash[k]) begin
        t_q[k] <= (k == 0) ? t_i : t_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  assign w0 = ONE - {1'b0, t_q[HASH_STAGES-1]};

  always_ff @(posedge clk_i) begin
    if (en_i.blend[0]) begin
      m0_q <= PW'(w0) * PW'(h0_i);
      m1_q <= PW'(t_q[HASH_STAGES-1]) * PW'(h1_i);
    end
  end

  assign sum = m0_q + m1_q;

  always_ff @(posedge clk_i) begin
    if (en_i.blend[1]) begin
      noise_q <= sum[FRAC_BITS+31 -: NOISE_W] ^ SIGN_FLIP;
    end
  end

  assign noise_o = noise_q;

endmodule

// ===== rtl/core/hashed_value_noise_1d.sv =====
// Hashed 1-D value noise, top level: configuration registers, stage control
// and the lattice, hash and blend pipeline. Uses hvn_pkg and the hvn_* modules.
//
// One position is taken per clock and one noise value leaves per clock once the
// pipeline is full and the output is not stalled; it has ten register stages (two
// for the lattice multiply and seed add, six for the hash multiplies and adds,
// two for the blend multiply and sum). A stall on the output backs up only stages
// that hold an item, so empty stages keep filling and nothing is lost or repeated.
module hashed_value_noise_1d #(
  parameter int unsigned FRAC_BITS = hvn_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hvn_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [hvn_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [hvn_pkg::POS_W-1:0]     position_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [hvn_pkg::NOISE_W-1:0] noise_value_o
);
  import hvn_pkg::*;

  logic [SCALE_W-1:0]    scale_q;
  logic [SEED_W-1:0]     seed_q;
  logic [NUM_STAGES-1:0] valid_q;
  logic [NUM_STAGES-1:0] en;
  stage_en_t             stage_en;
  logic [31:0]           q0, q1;
  logic [31:0]           h0, h1;
  logic [FRAC_BITS-1:0]  t;
  logic [NOISE_W-1:0]    noise;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_RESET;
      seed_q  <= SEED_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FREQ_SCALE: scale_q <= cfg_data_i[SCALE_W-1:0];
        CFG_NOISE_SEED: seed_q  <= cfg_data_i[SEED_W-1:0];
        default: ;
      endcase
    end
  end

  // advance a stage when it is empty or the stage after it advances
  always_comb begin
    en[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || !out_stall_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          valid_q[k] <= (k == 0) ? in_valid_i : valid_q[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  assign stage_en = stage_en_t'({en[LAT_STAGES-1:0],
                                 en[LAT_STAGES+HASH_STAGES-1:LAT_STAGES],
                                 en[NUM_STAGES-1:LAT_STAGES+HASH_STAGES]});

  hvn_lattice #(
    .FRAC_BITS(FRAC_BITS)
  ) u_lattice (
    .clk_i      (clk_i),
    .en_i       (stage_en.lat),
    .position_i (position_i),
    .scale_i    (scale_q),
    .seed_i     (seed_q),
    .q0_o       (q0),
    .q1_o       (q1),
    .t_o        (t)
  );

  hvn_hash u_hash0 (
    .clk_i (clk_i),
    .en_i  (stage_en.hash),
    .q_i   (q0),
    .h_o   (h0)
  );

  hvn_hash u_hash1 (
    .clk_i (clk_i),
    .en_i  (stage_en.hash),
    .q_i   (q1),
    .h_o   (h1)
  );

  hvn_blend #(
    .FRAC_BITS(FRAC_BITS)
  ) u_blend (
    .clk_i   (clk_i),
    .en_i    (stage_en),
    .t_i     (t),
    .h0_i    (h0),
    .h1_i    (h1),
    .noise_o (noise)
  );

  assign in_stall_o    = !en[0];
  assign out_valid_o   = valid_q[NUM_STAGES-1];
  assign noise_value_o = signed'(noise);

endmodule

// ===== rtl/core/hvn_checker.sv =====
// Port-level checks for hashed_value_noise_1d, attached by bind.
// Depends on hvn_pkg and the top level's ports.
module hvn_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [hvn_pkg::NOISE_W-1:0]   noise_value_o
);
  import hvn_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled result request dropped");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(noise_value_o))
    else $error("stalled result request changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output drains");

  assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result request valid during reset");

endmodule

bind hashed_value_noise_1d hvn_checker u_hvn_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .noise_value_o (noise_value_o)
);
